// ----- design/bist_pkg.sv -----
// Shared types and constants for the bounded integer set table.
// No dependencies; imported by the core and by its port checker.
`default_nettype none

package bist_pkg;

    // Store geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 6;
    localparam int SIZE_W = 7;
    localparam int CAP_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ACT,
        ST_MOVE,
        ST_RESP
    } state_t;

endpackage : bist_pkg

`default_nettype wire

// ----- design/bounded_integer_set_table_core.sv -----
// Bounded integer set table: set of distinct 32-bit integers kept in one
// synchronous store plus a count. Depends on bist_pkg.
`default_nettype none

// Each request runs a linear search over the elements held, of which there
// are at most DEPTH = 64, and stops at a hit; clear skips the search. The
// search reads one store entry per cycle through the single read port; a hit
// remove adds a read of the last entry and a write-back into the freed slot.
// A new request is taken only once the previous one has placed its result in
// the output register; a finished result waits there without holding up the
// next request until that one is ready to respond. The store needs no
// clearing after reset: only entries below the count are ever read.
module bounded_integer_set_table_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          capacity_we,
    input  wire logic [bist_pkg::CAP_W-1:0]    capacity,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bist_pkg::OP_W-1:0]     op,
    input  wire logic signed [bist_pkg::VAL_W-1:0] value,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               found,
    output logic [bist_pkg::POS_W-1:0]         position,
    output logic                               changed,
    output logic [bist_pkg::SIZE_W-1:0]        size
);
    import bist_pkg::*;

    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W + 1 : CAP_W + 1;

    // Element store
    logic [VAL_W-1:0] elem_mem [DEPTH];

    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    op_t               op_reg, op_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              chg_reg, chg_next;
    logic [VAL_W-1:0]  rd_data_reg;

    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              changed_reg, changed_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [VAL_W-1:0]  wr_data;

    logic [LIM_W-1:0]  count_ext, cap_ext;
    logic              room;
    logic              hit_now;
    logic              out_free;

    // Room for one more element under both capacity and store depth
    assign count_ext = LIM_W'(count_reg);
    assign cap_ext   = LIM_W'(cap_reg);
    assign room      = (count_ext < cap_ext) && (count_ext < LIM_W'(DEPTH));

    assign hit_now  = pend_reg && (rd_data_reg == val_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = pos_reg;
    assign changed   = changed_reg;
    assign size      = size_reg;

    // Store write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            elem_mem[wr_addr] <= wr_data;
        end
    end

    // Store read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= elem_mem[rd_addr];
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (capacity_we)
        begin
            cap_reg <= capacity;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        scan_reg    <= scan_next;
        pidx_reg    <= pidx_next;
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        chg_reg     <= chg_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        changed_reg <= changed_next;
        size_reg    <= size_next;
    end

    // Sequencer: search, modify, write back, respond
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        chg_next       = chg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        pos_next       = pos_reg;
        changed_next   = changed_reg;
        size_next      = size_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = op_t'(op);
                    val_next  = value;
                    scan_next = '0;
                    hit_next  = 1'b0;
                    slot_next = '0;
                    chg_next  = 1'b0;
                    if (op_t'(op) == OP_CLEAR)
                    begin
                        chg_next   = (count_reg != '0);
                        count_next = '0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                // compare the entry read last cycle, issue the next read
                if (hit_now)
                begin
                    hit_next   = 1'b1;
                    slot_next  = pidx_reg;
                    state_next = ST_ACT;
                end
                else if (scan_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg[IDX_W-1:0];
                    pend_next = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_ACT;
                end
            end

            ST_ACT:
            begin
                state_next = ST_RESP;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (!hit_reg && room)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IDX_W-1:0];
                            wr_data    = val_reg;
                            count_next = count_reg + CNT_W'(1);
                            chg_next   = 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        // fetch the last entry to fill the freed slot
                        if (hit_reg)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = IDX_W'(count_reg - CNT_W'(1));
                            count_next = count_reg - CNT_W'(1);
                            chg_next   = 1'b1;
                            state_next = ST_MOVE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = slot_reg;
                wr_data    = rd_data_reg;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    pos_next       = hit_reg ? POS_W'(slot_reg) : '0;
                    changed_next   = chg_reg;
                    size_next      = SIZE_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : bounded_integer_set_table_core

`default_nettype wire

// ----- design/bist_port_checker.sv -----
// Port-level checker for the bounded integer set table core, with its bind.
// Depends on bist_pkg and bounded_integer_set_table_core.
`default_nettype none

module bist_port_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic                       found,
    input  wire logic [bist_pkg::POS_W-1:0]  position,
    input  wire logic                       changed,
    input  wire logic [bist_pkg::SIZE_W-1:0] size
);
    import bist_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable(found) && $stable(position) && $stable(changed) && $stable(size))
        else $error("result beat changed while stalled");

    // Missed lookup reports slot zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0)
        else $error("position nonzero on a miss");

    // Size never exceeds the store
    a_size_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, size} <= (SIZE_W + 1)'(DEPTH))
        else $error("size beyond store depth");

    // Found slot lies inside the set as it stood before the request
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> {1'b0, position} <= (POS_W + 1)'(size))
        else $error("found position outside the set");

endmodule : bist_port_checker

bind bounded_integer_set_table_core bist_port_checker u_bist_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .position  (position),
    .changed   (changed),
    .size      (size)
);

`default_nettype wire
